>>> src/amq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amq_pkg
// Shared types, codes and constants of the array min priority queue.
// ----------------------------------------------------------------------------
package amq_pkg;

  localparam int MAX_VERTICES_DEF = 256;

  localparam int KEY_W   = 32;
  localparam int VTX_W   = 8;
  localparam int FUNC_W  = 2;
  localparam int VCNT_W  = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  // distances at or above this value are unreachable
  localparam logic [KEY_W-1:0] KEY_INF = 32'h7FFF_FFFF;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEL_MIN  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DEC_KEY  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_VERTEX = 1'd1;

  localparam logic [VCNT_W-1:0] VERTEX_COUNT_RST  = 9'd256;
  localparam logic [VTX_W-1:0]  SOURCE_VERTEX_RST = 8'd0;

  typedef struct packed {
    logic [VTX_W-1:0] vertex;
    logic [KEY_W-1:0] key;
  } slot_t;

  // status of the slot scan unit
  typedef struct packed {
    logic dv;    // read data of the scanned slot is on the RAM output
    logic done;  // every slot below the limit has been delivered
  } scan_st_t;

endpackage

>>> src/amq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amq_if
// Handshake channels of the array min priority queue: operation input,
// result output and configuration write.
// ----------------------------------------------------------------------------
interface amq_in_if;
  logic                            valid;
  logic                            ready;
  logic [amq_pkg::FUNC_W-1:0]      func;
  logic [amq_pkg::VTX_W-1:0]       vertex;
  logic [amq_pkg::KEY_W-1:0]       key;

  modport source (output valid, func, vertex, key, input ready);
  modport sink   (input valid, func, vertex, key, output ready);
endinterface

interface amq_out_if;
  logic                            valid;
  logic                            ready;
  logic [amq_pkg::VTX_W-1:0]       out_vertex;
  logic [amq_pkg::KEY_W-1:0]       out_key;
  logic                            removed;
  logic                            empty_res;

  modport source (output valid, out_vertex, out_key, removed, empty_res, input ready);
  modport sink   (input valid, out_vertex, out_key, removed, empty_res, output ready);
endinterface

interface amq_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [amq_pkg::CFG_IDX_W-1:0]   index;
  logic [amq_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/amq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module amq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = amq_pkg::MAX_VERTICES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/amq_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amq_scan
// Slot walker: issues one RAM read per cycle for slots 0 .. limit-1 and
// tags the returning read data with its slot index.
// ----------------------------------------------------------------------------
module amq_scan #(
  parameter int MAX_VERTICES = amq_pkg::MAX_VERTICES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [$clog2(MAX_VERTICES+1)-1:0] limit,
  output logic [$clog2(MAX_VERTICES)-1:0]   addr,
  output logic [$clog2(MAX_VERTICES)-1:0]   didx,
  output amq_pkg::scan_st_t                 st
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  logic [CW-1:0] cnt_r;
  logic [CW-1:0] limit_r;
  logic          run_r;
  logic          dv_r;
  logic [AW-1:0] didx_r;
  logic          issue;
  logic          done;

  assign issue = run_r && (cnt_r < limit_r);
  assign done  = run_r && !issue && !dv_r;
  assign addr  = cnt_r[AW-1:0];
  assign didx  = didx_r;
  assign st.dv   = dv_r;
  assign st.done = done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      dv_r  <= 1'b0;
    end else if (start) begin
      run_r <= 1'b1;
      dv_r  <= 1'b0;
    end else begin
      dv_r <= issue;
      if (done) begin
        run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r   <= '0;
      limit_r <= limit;
    end else if (issue) begin
      cnt_r <= cnt_r + CW'(1);
    end
    didx_r <= cnt_r[AW-1:0];
  end

endmodule

>>> src/array_min_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_min_priority_queue
// Unsorted-array min priority queue with decrease-key for shortest paths.
// ----------------------------------------------------------------------------
// Channels: in_if carries an operation (func, vertex, key), out_if returns
// exactly one result per operation (out_vertex, out_key, removed, empty_res),
// cfg_if writes vertex_count (index 0) and source_vertex (index 1); cfg_if is
// always ready, and the user must write it only while the queue is idle;
// the block does not enforce this. Slots live in one RAM with registered
// read; a single slot walker does all the scanning, one slot per cycle.
// Sequence: load, the unused code and a delete on an empty queue go straight
//   to the result; delete-min reads the minimum, the swap slot and the last
//   slot, writes the two back swapped and rescans the remaining slots;
//   decrease-key reads the minimum slot, then scans every slot.
// The block works on one operation at a time; in_if.ready is high only when
// idle. A finished result sits in the output register, and the next
// operation is taken while it waits; a further result holds the sequencer
// until out_if.ready frees the register.
// Reset clears the count and the minimum pointer and loads the register
// defaults; slot contents are undefined until loaded.
// ----------------------------------------------------------------------------
module array_min_priority_queue #(
  parameter int MAX_VERTICES = amq_pkg::MAX_VERTICES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  amq_in_if.sink    in_if,
  amq_out_if.source out_if,
  amq_cfg_if.sink   cfg_if
);

  localparam int AW  = $clog2(MAX_VERTICES);
  localparam int CW  = $clog2(MAX_VERTICES + 1);
  localparam int CXW = (CW > amq_pkg::VCNT_W) ? CW : amq_pkg::VCNT_W;
  // one bit above the slot index so that MAX_VERTICES itself is representable
  localparam int SXW = ((AW > amq_pkg::VTX_W) ? AW : amq_pkg::VTX_W) + 1;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_DRDM  = 11'b000_0000_0010,
    S_DRDI  = 11'b000_0000_0100,
    S_DRDL  = 11'b000_0000_1000,
    S_DWRI  = 11'b000_0001_0000,
    S_DWRL  = 11'b000_0010_0000,
    S_DSCAN = 11'b000_0100_0000,
    S_KRDM  = 11'b000_1000_0000,
    S_KINIT = 11'b001_0000_0000,
    S_KSCAN = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [amq_pkg::VCNT_W-1:0] vcount_r;
  logic [amq_pkg::VTX_W-1:0]  src_r;
  logic [CW-1:0]              count_r;
  logic [AW-1:0]              min_r;
  logic [amq_pkg::KEY_W-1:0]  best_r;
  logic [amq_pkg::KEY_W-1:0]  min_key_r;
  logic [amq_pkg::VTX_W-1:0]  vtx_r;
  logic [amq_pkg::KEY_W-1:0]  key_r;
  amq_pkg::slot_t             hold_r;
  logic [amq_pkg::VTX_W-1:0]  res_v_r;
  logic [amq_pkg::KEY_W-1:0]  res_k_r;
  logic                       rem_r;
  logic                       out_valid_r;
  logic [amq_pkg::VTX_W-1:0]  out_vertex_r;
  logic [amq_pkg::KEY_W-1:0]  out_key_r;
  logic                       out_rem_r;
  logic                       out_empty_r;

  logic           accept;
  logic           out_free;
  logic           load_in_range;
  logic [CW-1:0]  count_clamp;
  logic [AW-1:0]  src_clamp;
  logic [CW-1:0]  last_c;
  logic [AW-1:0]  idx_c;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  amq_pkg::slot_t ram_wdata;
  logic [AW-1:0]  ram_raddr;
  amq_pkg::slot_t ram_rdata;
  logic           scan_start;
  logic [CW-1:0]  scan_limit;
  logic [AW-1:0]  scan_addr;
  logic [AW-1:0]  scan_didx;
  amq_pkg::scan_st_t scan_st;
  logic           key_match;

  assign accept   = in_if.valid && in_if.ready;
  assign out_free = !out_valid_r || out_if.ready;
  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;

  assign out_if.valid      = out_valid_r;
  assign out_if.out_vertex = out_vertex_r;
  assign out_if.out_key    = out_key_r;
  assign out_if.removed    = out_rem_r;
  assign out_if.empty_res  = out_empty_r;

  // register clamping against the slot count
  assign count_clamp = (CXW'(vcount_r) > CXW'(MAX_VERTICES)) ?
                       CW'(MAX_VERTICES) : CW'(vcount_r);
  assign src_clamp   = (SXW'(src_r) >= SXW'(MAX_VERTICES)) ?
                       AW'(MAX_VERTICES - 1) : AW'(src_r);
  assign load_in_range = (32'(in_if.vertex) < 32'(MAX_VERTICES));

  // delete-min swap: stale minimum swaps slot 0 with the last slot
  assign last_c = count_r - CW'(1);
  assign idx_c  = (CW'(min_r) < count_r) ? min_r : '0;

  assign key_match = scan_st.dv && (ram_rdata.vertex == vtx_r);

  always_comb begin
    ram_raddr = scan_addr;
    case (state_r)
      S_DRDM:  ram_raddr = min_r;
      S_DRDI:  ram_raddr = idx_c;
      S_DRDL:  ram_raddr = last_c[AW-1:0];
      S_KRDM:  ram_raddr = min_r;
      default: ram_raddr = scan_addr;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = scan_didx;
    ram_wdata = ram_rdata;
    case (state_r)
      S_IDLE: begin
        ram_we           = accept && (in_if.func == amq_pkg::FUNC_LOAD) && load_in_range;
        ram_waddr        = AW'(in_if.vertex);
        ram_wdata.vertex = in_if.vertex;
        ram_wdata.key    = in_if.key;
      end
      S_DWRI: begin
        ram_we    = 1'b1;
        ram_waddr = idx_c;
        ram_wdata = ram_rdata;
      end
      S_DWRL: begin
        ram_we    = 1'b1;
        ram_waddr = last_c[AW-1:0];
        ram_wdata = hold_r;
      end
      S_KSCAN: begin
        ram_we           = key_match;
        ram_waddr        = scan_didx;
        ram_wdata.vertex = ram_rdata.vertex;
        ram_wdata.key    = key_r;
      end
      default: ram_we = 1'b0;
    endcase
  end

  assign scan_start = (state_r == S_DWRL) || (state_r == S_KINIT);
  assign scan_limit = (state_r == S_DWRL) ? last_c : count_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_if.func)
            amq_pkg::FUNC_DEL_MIN: state_nxt = (count_r != '0) ? S_DRDM : S_DONE;
            amq_pkg::FUNC_DEC_KEY: state_nxt = S_KRDM;
            default:               state_nxt = S_DONE;
          endcase
        end
      end
      S_DRDM:  state_nxt = S_DRDI;
      S_DRDI:  state_nxt = S_DRDL;
      S_DRDL:  state_nxt = S_DWRI;
      S_DWRI:  state_nxt = S_DWRL;
      S_DWRL:  state_nxt = S_DSCAN;
      S_DSCAN: state_nxt = scan_st.done ? S_DONE : S_DSCAN;
      S_KRDM:  state_nxt = S_KINIT;
      S_KINIT: state_nxt = S_KSCAN;
      S_KSCAN: state_nxt = scan_st.done ? S_DONE : S_KSCAN;
      S_DONE:  state_nxt = out_free ? S_IDLE : S_DONE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      min_r       <= '0;
      vcount_r    <= amq_pkg::VERTEX_COUNT_RST;
      src_r       <= amq_pkg::SOURCE_VERTEX_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          amq_pkg::CFG_VERTEX_COUNT:  vcount_r <= cfg_if.data;
          amq_pkg::CFG_SOURCE_VERTEX: src_r    <= cfg_if.data[amq_pkg::VTX_W-1:0];
          default: ;
        endcase
      end
      if (accept && (in_if.func == amq_pkg::FUNC_LOAD)) begin
        count_r <= count_clamp;
        min_r   <= src_clamp;
      end
      if (state_r == S_DWRL) begin
        count_r <= last_c;
      end
      if ((state_r == S_DSCAN) && scan_st.dv && (ram_rdata.key < best_r)) begin
        min_r <= scan_didx;
      end
      if ((state_r == S_DSCAN) && scan_st.done && (best_r == amq_pkg::KEY_INF)) begin
        min_r <= '0;
      end
      if ((state_r == S_KSCAN) && key_match && (min_r != scan_didx) &&
          (min_key_r > key_r)) begin
        min_r <= scan_didx;
      end
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      vtx_r   <= in_if.vertex;
      key_r   <= in_if.key;
      res_v_r <= '0;
      res_k_r <= '0;
      rem_r   <= 1'b0;
    end
    if (state_r == S_DRDI) begin
      res_v_r <= ram_rdata.vertex;
      res_k_r <= ram_rdata.key;
      rem_r   <= 1'b1;
    end
    if (state_r == S_DRDL) begin
      hold_r <= ram_rdata;
    end
    if (state_r == S_DWRL) begin
      best_r <= amq_pkg::KEY_INF;
    end
    if ((state_r == S_DSCAN) && scan_st.dv && (ram_rdata.key < best_r)) begin
      best_r <= ram_rdata.key;
    end
    if (state_r == S_KINIT) begin
      min_key_r <= ram_rdata.key;
    end
    // min_key_r tracks the key stored at the minimum slot
    if ((state_r == S_KSCAN) && key_match &&
        ((min_r == scan_didx) || (min_key_r > key_r))) begin
      min_key_r <= key_r;
    end
    if ((state_r == S_DONE) && out_free) begin
      out_vertex_r <= res_v_r;
      out_key_r    <= res_k_r;
      out_rem_r    <= rem_r;
      out_empty_r  <= (count_r == '0);
    end
  end

  amq_ram #(
    .WIDTH ($bits(amq_pkg::slot_t)),
    .DEPTH (MAX_VERTICES)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  amq_scan #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (scan_start),
    .limit (scan_limit),
    .addr  (scan_addr),
    .didx  (scan_didx),
    .st    (scan_st)
  );

endmodule

>>> src/amq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amq_checker
// Port-level checks of the array min priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module amq_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [amq_pkg::VTX_W-1:0]   out_vertex,
  input logic [amq_pkg::KEY_W-1:0]   out_key,
  input logic                        removed,
  input logic                        empty_res
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_vertex) &&
    $stable(out_key) && $stable(removed) && $stable(empty_res))
    else $error("stalled result changed");

  // one operation at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // a new result only comes out of a busy period
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without operation");

  // nothing removed means zero payload
  a_no_removal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !removed |-> (out_vertex == '0) && (out_key == '0))
    else $error("payload without removal");

endmodule

bind array_min_priority_queue amq_checker u_amq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_vertex (out_if.out_vertex),
  .out_key    (out_if.out_key),
  .removed    (out_if.removed),
  .empty_res  (out_if.empty_res)
);

>>> dv/array_min_priority_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_min_priority_queue_tb
// Self-checking bench for the array min priority queue. A short table of
// directed operations runs first. It is followed by random sessions that
// configure the queue, load it and then mix delete-min, decrease-key, reloads
// and the unused code. Every result is checked against a behavioral queue
// kept in the bench. Both channel sides idle at random.
// ----------------------------------------------------------------------------
module array_min_priority_queue_tb;
  import amq_pkg::*;

  localparam int NV = MAX_VERTICES_DEF;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_OPS = 1350;
  localparam int MAX_SHOWN = 10;
  localparam int CFG_COUNT_MAX = 511;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [VTX_W-1:0]  vertex;
    logic [KEY_W-1:0]  key;
  } queue_op_t;

  typedef struct packed {
    logic [VTX_W-1:0] vertex;
    logic [KEY_W-1:0] key;
    logic             removed;
    logic             empty;
  } queue_res_t;

  typedef enum logic {ROW_OP, ROW_REGS} row_kind_t;

  // ROW_REGS rows carry source_vertex in op.vertex and vertex_count in op.key
  typedef struct packed {
    row_kind_t  kind;
    queue_op_t  op;
    logic       pinned;
    queue_res_t res;
  } dir_row_t;

  localparam queue_res_t RES_NONE_EMPTY = {8'd0, 32'd0, 1'b0, 1'b1};
  localparam queue_res_t RES_NONE_LIVE  = {8'd0, 32'd0, 1'b0, 1'b0};

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #4 clk = ~clk;

  amq_in_if  in_ch ();
  amq_out_if out_ch ();
  amq_cfg_if cfg_ch ();

  array_min_priority_queue i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // behavioral queue
  logic [VTX_W-1:0] q_vtx [NV];
  logic [KEY_W-1:0] q_key [NV];
  bit               q_loaded [NV];
  int               q_count = 0;
  int               q_min = 0;
  int               reg_count = VERTEX_COUNT_RST;
  int               reg_source = SOURCE_VERTEX_RST;

  queue_res_t expected_results [$];

  int  err_cnt = 0;
  int  ops_sent = 0;
  int  results_seen = 0;
  int  removes_seen = 0;
  int  settings_cnt = 0;
  int  sessions = 0;
  int  out_hold = 0;
  bit  steady = 1'b0;

  function automatic queue_res_t apply_queue_op(input queue_op_t op);
    queue_res_t       r;
    int               idx;
    int               last;
    logic [VTX_W-1:0] tv;
    logic [KEY_W-1:0] tk;
    logic [KEY_W-1:0] best;
    r = '0;
    case (op.func)
      FUNC_LOAD: begin
        q_vtx[op.vertex] = op.vertex;
        q_key[op.vertex] = op.key;
        q_loaded[op.vertex] = 1'b1;
        q_count = (reg_count > NV) ? NV : reg_count;
        q_min = (reg_source >= NV) ? NV - 1 : reg_source;
      end
      FUNC_DEL_MIN: begin
        if (q_count != 0) begin
          // stale pointer: the entry at q_min leaves, but slot 0 is swapped
          idx = (q_min < q_count) ? q_min : 0;
          last = q_count - 1;
          r.vertex = q_vtx[q_min];
          r.key = q_key[q_min];
          r.removed = 1'b1;
          tv = q_vtx[idx];
          tk = q_key[idx];
          q_vtx[idx] = q_vtx[last];
          q_key[idx] = q_key[last];
          q_vtx[last] = tv;
          q_key[last] = tk;
          q_count = last;
          best = KEY_INF;
          for (int i = 0; i < q_count; i++) begin
            if (q_key[i] < best) begin
              best = q_key[i];
              q_min = i;
            end
          end
          if (best == KEY_INF) q_min = 0;
        end
      end
      FUNC_DEC_KEY: begin
        for (int i = 0; i < q_count; i++) begin
          if (q_vtx[i] == op.vertex) begin
            q_key[i] = op.key;
            if (q_key[q_min] > op.key) q_min = i;
          end
        end
      end
      default: ;
    endcase
    r.empty = (q_count == 0);
    return r;
  endfunction

  // slot that an op would read before any load wrote it, -1 if none
  function automatic int unloaded_slot(input logic [FUNC_W-1:0] f);
    if (f != FUNC_DEL_MIN && f != FUNC_DEC_KEY) return -1;
    if (q_count == 0) return -1;
    if (!q_loaded[q_min]) return q_min;
    for (int i = 0; i < q_count; i++) begin
      if (!q_loaded[i]) return i;
    end
    return -1;
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    case ($urandom_range(0, 9))
      0, 1, 2: return KEY_W'($urandom_range(0, 15));
      3:       return KEY_W'($urandom_range(0, 1000));
      4:       return KEY_INF;
      5:       return KEY_INF + KEY_W'($urandom_range(1, 3));
      6:       return 32'hFFFF_FFFF - KEY_W'($urandom_range(0, 3));
      default: return KEY_W'($urandom());
    endcase
  endfunction

  task automatic send_op(input queue_op_t op, input bit pinned, input queue_res_t pinned_res);
    int         gap;
    queue_res_t r;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= op.func;
    in_ch.vertex <= op.vertex;
    in_ch.key <= op.key;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = apply_queue_op(op);
    expected_results.push_back(pinned ? pinned_res : r);
    ops_sent++;
  endtask

  // every op yields one result, so an empty expectation queue means idle
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic write_regs(input int count, input int source);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_VERTEX_COUNT;
    cfg_ch.data <= CFG_DATA_W'(count);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    reg_count = count;
    cfg_ch.index <= CFG_SOURCE_VERTEX;
    cfg_ch.data <= CFG_DATA_W'(source);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    reg_source = source;
    cfg_ch.valid <= 1'b0;
    settings_cnt++;
  endtask

  task automatic load_slot(input int slot);
    queue_op_t op;
    op = '{FUNC_LOAD, VTX_W'(slot), rand_key()};
    send_op(op, 1'b0, '0);
  endtask

  // one session: new register setting, fill the queue, then mixed traffic
  task automatic run_session();
    int        pick;
    int        n;
    int        n_eff;
    int        src;
    int        rot;
    int        nops;
    int        slot;
    int        miss;
    bit        broken;
    queue_op_t op;
    pick = $urandom_range(0, 99);
    if (pick < 55) n = $urandom_range(1, 8);
    else if (pick < 75) n = $urandom_range(9, 40);
    else if (pick < 81) n = 0;
    else if (pick < 88) n = NV;
    else if (pick < 93) n = $urandom_range(NV + 1, CFG_COUNT_MAX);
    else n = $urandom_range(41, NV - 1);
    n_eff = (n > NV) ? NV : n;
    src = ($urandom_range(0, 3) != 0 && n_eff > 0) ? $urandom_range(0, n_eff - 1)
                                                    : $urandom_range(0, NV - 1);
    steady = ($urandom_range(0, 4) == 0);
    broken = ($urandom_range(0, 6) == 0);
    sessions++;
    write_regs(n, src);

    rot = (n_eff > 0) ? $urandom_range(0, n_eff - 1) : 0;
    for (int i = 0; i < n_eff; i++) begin
      slot = (i + rot) % n_eff;
      if (broken && $urandom_range(0, 1) == 1) continue;
      // big queues only need the slots that were never loaded, plus a few
      if (n_eff > 40 && q_loaded[slot] && $urandom_range(0, 15) != 0) continue;
      load_slot(slot);
    end
    if (src >= n_eff && (!q_loaded[src] || $urandom_range(0, 1) == 1)) load_slot(src);

    nops = (n_eff <= 10) ? 2 * n_eff + 3 : $urandom_range(12, 30);
    repeat (nops) begin
      pick = $urandom_range(0, 99);
      op.key = rand_key();
      op.vertex = (n_eff > 0) ? VTX_W'($urandom_range(0, n_eff - 1)) : '0;
      if (pick < 50) begin
        op.func = FUNC_DEL_MIN;
      end else if (pick < 82) begin
        op.func = FUNC_DEC_KEY;
        if (pick >= 78) op.vertex = VTX_W'($urandom_range(0, NV - 1));
      end else if (pick < 92) begin
        op.func = FUNC_LOAD;
      end else begin
        op.func = FUNC_UNUSED;
        op.vertex = VTX_W'($urandom_range(0, NV - 1));
      end
      miss = unloaded_slot(op.func);
      if (miss >= 0) begin
        op.func = FUNC_LOAD;
        op.vertex = VTX_W'(miss);
      end
      send_op(op, 1'b0, '0);
      if ($urandom_range(0, 39) == 0) drain();
    end
  endtask

  task automatic check_result(input queue_res_t got);
    queue_res_t want;
    results_seen++;
    if (expected_results.size() == 0) begin
      err_cnt++;
      if (err_cnt <= MAX_SHOWN)
        $display("Unexpected result %0d: vertex=%0d key=%h removed=%0b empty=%0b",
                 results_seen, got.vertex, got.key, got.removed, got.empty);
      return;
    end
    want = expected_results.pop_front();
    if (got.removed === 1'b1) removes_seen++;
    if (got.vertex !== want.vertex || got.key !== want.key ||
        got.removed !== want.removed || got.empty !== want.empty) begin
      err_cnt++;
      if (err_cnt <= MAX_SHOWN)
        $display("Mismatch on result %0d: exp vertex=%0d key=%h removed=%0b empty=%0b",
                 results_seen, want.vertex, want.key, want.removed, want.empty,
                 " / got vertex=%0d key=%h removed=%0b empty=%0b",
                 got.vertex, got.key, got.removed, got.empty);
    end
  endtask

  // result sink with random back-pressure
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        check_result({out_ch.out_vertex, out_ch.out_key, out_ch.removed, out_ch.empty_res});
        out_hold = steady ? 0 : $urandom_range(0, 6);
      end else if (out_hold > 0) begin
        out_hold--;
      end
      out_ch.ready <= (out_hold == 0);
    end
  end

  initial begin
    dir_row_t rows [$];
    int       dir_ops;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_LOAD;
    in_ch.vertex = '0;
    in_ch.key = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_VERTEX_COUNT;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;

    rows = '{
      // empty queue straight after reset
      '{ROW_OP,   '{FUNC_DEL_MIN, 8'd0,   32'd0},         1'b1, RES_NONE_EMPTY},
      '{ROW_OP,   '{FUNC_DEC_KEY, 8'd5,   32'd7},         1'b1, RES_NONE_EMPTY},
      '{ROW_OP,   '{FUNC_UNUSED,  8'hFF,  32'hFFFF_FFFF}, 1'b1, RES_NONE_EMPTY},
      // four vertices, source 2
      '{ROW_REGS, '{FUNC_LOAD,    8'd2,   32'd4},         1'b0, '0},
      '{ROW_OP,   '{FUNC_LOAD,    8'd0,   32'd0},         1'b1, RES_NONE_LIVE},
      '{ROW_OP,   '{FUNC_LOAD,    8'd1,   32'hFFFF_FFFF}, 1'b1, RES_NONE_LIVE},
      '{ROW_OP,   '{FUNC_LOAD,    8'd2,   KEY_INF},       1'b1, RES_NONE_LIVE},
      '{ROW_OP,   '{FUNC_LOAD,    8'd3,   32'd100},       1'b1, RES_NONE_LIVE},
      '{ROW_OP,   '{FUNC_DEL_MIN, 8'd0,   32'd0},         1'b0, '0},
      '{ROW_OP,   '{FUNC_DEC_KEY, 8'd1,   32'd50},        1'b0, '0},
      '{ROW_OP,   '{FUNC_DEC_KEY, 8'd3,   32'd0},         1'b0, '0},
      '{ROW_OP,   '{FUNC_DEL_MIN, 8'd0,   32'd0},         1'b0, '0},
      '{ROW_OP,   '{FUNC_DEL_MIN, 8'd0,   32'd0},         1'b0, '0},
      '{ROW_OP,   '{FUNC_DEL_MIN, 8'd0,   32'd0},         1'b0, '0},
      '{ROW_OP,   '{FUNC_DEL_MIN, 8'd0,   32'd0},         1'b1, RES_NONE_EMPTY},
      // source past the count: stale minimum pointer
      '{ROW_REGS, '{FUNC_LOAD,    8'd255, 32'd2},         1'b0, '0},
      '{ROW_OP,   '{FUNC_LOAD,    8'd255, 32'd5},         1'b1, RES_NONE_LIVE},
      '{ROW_OP,   '{FUNC_DEL_MIN, 8'd0,   32'd0},         1'b0, '0},
      '{ROW_OP,   '{FUNC_DEC_KEY, 8'd3,   KEY_INF},       1'b0, '0},
      '{ROW_OP,   '{FUNC_DEL_MIN, 8'd0,   32'd0},         1'b0, '0},
      // zero vertex count: a load leaves the queue empty
      '{ROW_REGS, '{FUNC_LOAD,    8'd0,   32'd0},         1'b0, '0},
      '{ROW_OP,   '{FUNC_LOAD,    8'd128, 32'h8000_0000}, 1'b1, RES_NONE_EMPTY},
      '{ROW_OP,   '{FUNC_DEL_MIN, 8'd0,   32'd0},         1'b1, RES_NONE_EMPTY}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[k]) begin
      if (rows[k].kind == ROW_REGS) write_regs(int'(rows[k].op.key), int'(rows[k].op.vertex));
      else send_op(rows[k].op, rows[k].pinned, rows[k].res);
    end
    dir_ops = ops_sent;

    while (ops_sent < dir_ops + RANDOM_OPS) run_session();

    drain();
    // leave room for a delete over a full queue to finish
    repeat (NV + 40) @(posedge clk);
    err_cnt += expected_results.size();

    $display("Covered %0d operations (%0d directed) in %0d random sessions, %0d settings",
             ops_sent, dir_ops, sessions, settings_cnt);
    $display("Checked %0d results, %0d removed a minimum; %0d failures",
             results_seen, removes_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
